// ----- design/fmdc_pkg.sv -----
package fmdc_pkg;

  localparam int DEF_ROWS = 32;
  localparam int DEF_COLS = 64;

  // Request function codes.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_PROC  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_CHANCE = 2'd1;
  localparam logic [1:0] CFG_SLACK  = 2'd2;

  // Raster passes of a frame.
  localparam logic [1:0] PASS_DIL = 2'd0;
  localparam logic [1:0] PASS_ERO = 2'd1;
  localparam logic [1:0] PASS_FWD = 2'd2;
  localparam logic [1:0] PASS_BWD = 2'd3;

  // Per-cell steps: five neighbor reads, then the write-back step.
  localparam logic [2:0] NB_CENTER  = 3'd0;
  localparam logic [2:0] NB_UP      = 3'd1;
  localparam logic [2:0] NB_DOWN    = 3'd2;
  localparam logic [2:0] NB_LEFT    = 3'd3;
  localparam logic [2:0] NB_RIGHT   = 3'd4;
  localparam logic [2:0] STEP_WRITE = 3'd6;

  localparam logic [2:0] CLASS_AIR  = 3'd0;
  localparam logic [2:0] CLASS_BODY = 3'd1;
  localparam logic [2:0] CLASS_RIM  = 3'd2;
  localparam logic [2:0] TIER_MAX   = 3'd5;

  localparam logic [6:0] DEPTH_CAP = 7'd100;
  localparam logic [8:0] JITTER    = 9'd24;

  localparam logic [31:0] HASH_COL  = 32'd73856093;
  localparam logic [31:0] HASH_ROW  = 32'd19349663;
  localparam logic [31:0] HASH_FRM  = 32'd83492791;
  localparam logic [31:0] HASH_MIX  = 32'd2654435761;
  // ceil(2^38 / 100): exact quotient by 100 for any 32-bit value.
  localparam logic [31:0] RECIP_100 = 32'd2748779070;
  localparam int          RECIP_SH  = 38;

  localparam int         MOD_BITS = 24;
  localparam logic [4:0] MOD_LAST = 5'd24;

  typedef struct packed {
    logic       clear_wr;
    logic       count_wr;
    logic       frame_ld;
    logic       read_ld;
    logic       cells_begin;
    logic       begin_bwd;
    logic       cell_next;
    logic       bwd;
    logic       issue;
    logic [2:0] step;
    logic       acc_init;
    logic       pass_wr;
    logic [1:0] pass;
    logic       mod_init;
    logic       mod_step;
    logic       finish;
    logic       out_zero;
  } fmdc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic cell_last;
    logic in_inside;
  } fmdc_sts_t;

  function automatic logic [7:0] tier_alpha(input logic [2:0] t);
    logic [7:0] a;
    case (t)
      3'd1:    a = 8'd84;
      3'd2:    a = 8'd112;
      3'd3:    a = 8'd160;
      3'd4:    a = 8'd208;
      3'd5:    a = 8'd240;
      default: a = 8'd0;
    endcase
    return a;
  endfunction

  function automatic logic [15:0] tier_color(input logic [2:0] t);
    logic [15:0] c;
    case (t)
      3'd1:    c = 16'h57FF;
      3'd2:    c = 16'h37FF;
      3'd3:    c = 16'h07FF;
      3'd4:    c = 16'h17FF;
      3'd5:    c = 16'h47FF;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

// ----- design/fmdc_ctrl.sv -----
module fmdc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            func,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  fmdc_pkg::fmdc_sts_t   sts,
  output fmdc_pkg::fmdc_cmd_t   cmd
);
  import fmdc_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CELL  = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] pass, pass_next;
  logic [2:0] step, step_next;
  logic [4:0] cnt, cnt_next;
  logic       is_read, is_read_next;
  logic       accept;

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    pass_next    = pass;
    step_next    = step;
    cnt_next     = cnt;
    is_read_next = is_read;
    cmd          = '0;
    cmd.pass     = pass;
    cmd.step     = step;
    cmd.bwd      = (pass == PASS_BWD);
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_WRITE: cmd.count_wr = 1'b1;
            FUNC_PROC: begin
              cmd.frame_ld    = 1'b1;
              cmd.cells_begin = 1'b1;
              cmd.begin_bwd   = 1'b0;
              pass_next       = PASS_DIL;
              step_next       = NB_CENTER;
              is_read_next    = 1'b0;
              state_next      = ST_CELL;
            end
            FUNC_READ: begin
              if (sts.in_inside) begin
                cmd.read_ld  = 1'b1;
                is_read_next = 1'b1;
                step_next    = NB_CENTER;
                state_next   = ST_CELL;
              end else begin
                cmd.out_zero = 1'b1;
                state_next   = ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CELL: begin
        cmd.issue    = (step <= NB_RIGHT);
        cmd.acc_init = (step == NB_CENTER);
        step_next    = 3'(step + 3'd1);
        if (step == STEP_WRITE) begin
          step_next = NB_CENTER;
          if (is_read) begin
            cmd.mod_init = 1'b1;
            cnt_next     = '0;
            state_next   = ST_MOD;
          end else begin
            cmd.pass_wr = 1'b1;
            if (sts.cell_last) begin
              if (pass == PASS_BWD) begin
                state_next = ST_IDLE;
              end else begin
                pass_next       = 2'(pass + 2'd1);
                cmd.cells_begin = 1'b1;
                cmd.begin_bwd   = (2'(pass + 2'd1) == PASS_BWD);
              end
            end else begin
              cmd.cell_next = 1'b1;
            end
          end
        end
      end
      ST_MOD: begin
        if (cnt == MOD_LAST) begin
          cmd.finish = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.mod_step = 1'b1;
          cnt_next     = 5'(cnt + 5'd1);
        end
      end
      ST_DONE: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      pass    <= PASS_DIL;
      step    <= NB_CENTER;
      cnt     <= '0;
      is_read <= 1'b0;
    end else begin
      state   <= state_next;
      pass    <= pass_next;
      step    <= step_next;
      cnt     <= cnt_next;
      is_read <= is_read_next;
    end
  end

endmodule

// ----- design/fmdc_datapath.sv -----
module fmdc_datapath #(
  parameter int ROWS = fmdc_pkg::DEF_ROWS,
  parameter int COLS = fmdc_pkg::DEF_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fmdc_pkg::fmdc_cmd_t  cmd,
  output fmdc_pkg::fmdc_sts_t  sts,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [6:0]           cfg_data,
  input  logic [4:0]           row,
  input  logic [5:0]           col,
  input  logic [7:0]           particle_count,
  input  logic [31:0]          frame_number,
  output logic [2:0]           cell_class,
  output logic [7:0]           alpha,
  output logic [15:0]          tier_color,
  output logic                 sparkle,
  output logic [3:0]           sparkle_dx,
  output logic [3:0]           sparkle_dy
);
  import fmdc_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

  logic [7:0] count_mem [CELLS];
  logic       dil_mem   [CELLS];
  logic       fluid_mem [CELLS];
  logic [6:0] depth_mem [CELLS];

  logic          render_mode;
  logic [6:0]    chance;
  logic [3:0]    slack;
  logic [31:0]   frame_latch;

  logic [RW-1:0] cur_r, nr;
  logic [CW-1:0] cur_c, nc;
  logic          inb;
  logic [AW-1:0] cur_addr, nb_addr, in_addr, clr_addr;

  logic [7:0]    count_rd;
  logic          dil_rd, fluid_rd;
  logic [6:0]    depth_rd;
  logic          tag_vld, tag_inb;
  logic [2:0]    tag_k;

  logic          acc_any, acc_all, acc_rim, cen_fl;
  logic [6:0]    acc_min, cen_dep, cham;
  logic [7:0]    cen_cnt;
  logic          min_sel;

  logic [31:0]   p_col, p_row, p_frm, h_q, h3, h2;
  logic [63:0]   qprod;
  logic [6:0]    hmod;
  logic [23:0]   dvx, dvy;
  logic [4:0]    rx, ry, tx, ty;

  logic          fluid_we, fluid_wd, depth_we;
  logic [AW-1:0] fluid_wa;
  logic [6:0]    depth_wd;

  logic [2:0]    f_class, tier;
  logic [7:0]    f_alpha;
  logic [15:0]   f_color;
  logic          f_spk;
  logic [3:0]    f_dx, f_dy;
  logic [8:0]    a9;

  // Configuration and frame latch.
  always_ff @(posedge clk) begin
    if (rst) begin
      render_mode <= 1'b0;
      chance      <= 7'd10;
      slack       <= 4'd2;
      frame_latch <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:   render_mode <= cfg_data[0];
          CFG_CHANCE: chance      <= cfg_data;
          CFG_SLACK:  slack       <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.frame_ld) frame_latch <= frame_number;
    end
  end

  // Cell walker.
  always_ff @(posedge clk) begin
    if (cmd.read_ld) begin
      cur_r <= RW'(row);
      cur_c <= CW'(col);
    end else if (cmd.cells_begin) begin
      cur_r <= cmd.begin_bwd ? RW'(ROWS - 1) : '0;
      cur_c <= cmd.begin_bwd ? CW'(COLS - 1) : '0;
    end else if (cmd.cell_next) begin
      if (cmd.bwd) begin
        if (cur_c == '0) begin
          cur_c <= CW'(COLS - 1);
          cur_r <= cur_r - RW'(1);
        end else begin
          cur_c <= cur_c - CW'(1);
        end
      end else begin
        if (cur_c == CW'(COLS - 1)) begin
          cur_c <= '0;
          cur_r <= cur_r + RW'(1);
        end else begin
          cur_c <= cur_c + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear_wr) clr_addr <= clr_addr + AW'(1);
  end

  assign sts.clear_last = (clr_addr == AW'(CELLS - 1));
  assign sts.cell_last  = cmd.bwd ? (cur_r == '0 && cur_c == '0)
                                  : (cur_r == RW'(ROWS - 1) && cur_c == CW'(COLS - 1));
  assign sts.in_inside  = (32'(row) < ROWS) && (32'(col) < COLS);

  always_comb begin
    nr  = cur_r;
    nc  = cur_c;
    inb = 1'b1;
    case (cmd.step)
      NB_UP: begin
        inb = (cur_r != '0);
        nr  = cur_r - RW'(1);
      end
      NB_DOWN: begin
        inb = (cur_r != RW'(ROWS - 1));
        nr  = cur_r + RW'(1);
      end
      NB_LEFT: begin
        inb = (cur_c != '0);
        nc  = cur_c - CW'(1);
      end
      NB_RIGHT: begin
        inb = (cur_c != CW'(COLS - 1));
        nc  = cur_c + CW'(1);
      end
      default: ;
    endcase
    if (!inb) begin
      nr = cur_r;
      nc = cur_c;
    end
  end

  assign nb_addr  = AW'(32'(nr) * COLS + 32'(nc));
  assign cur_addr = AW'(32'(cur_r) * COLS + 32'(cur_c));
  assign in_addr  = AW'(32'(row) * COLS + 32'(col));

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.count_wr && sts.in_inside) count_mem[in_addr] <= particle_count;
    count_rd <= count_mem[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_wr && cmd.pass == PASS_DIL) dil_mem[cur_addr] <= acc_any;
    dil_rd <= dil_mem[nb_addr];
  end

  assign cham = (cen_dep != '0 && 7'(acc_min + 7'd1) < cen_dep) ? 7'(acc_min + 7'd1) : cen_dep;

  always_comb begin
    fluid_we = cmd.clear_wr || (cmd.pass_wr && cmd.pass == PASS_ERO);
    fluid_wa = cmd.clear_wr ? clr_addr : cur_addr;
    fluid_wd = cmd.clear_wr ? 1'b0 : acc_all;
    depth_we = cmd.clear_wr || (cmd.pass_wr && cmd.pass != PASS_DIL);
    if (cmd.clear_wr)               depth_wd = '0;
    else if (cmd.pass == PASS_ERO)  depth_wd = acc_all ? DEPTH_CAP : 7'd0;
    else                            depth_wd = cham;
  end

  always_ff @(posedge clk) begin
    if (fluid_we) fluid_mem[fluid_wa] <= fluid_wd;
    fluid_rd <= fluid_mem[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (depth_we) depth_mem[fluid_wa] <= depth_wd;
    depth_rd <= depth_mem[nb_addr];
  end

  // Neighbor tags are registered alongside the read data, so they line up with it.
  always_ff @(posedge clk) begin
    if (rst) tag_vld <= 1'b0;
    else     tag_vld <= cmd.issue;
  end

  always_ff @(posedge clk) begin
    tag_k   <= cmd.step;
    tag_inb <= inb;
  end

  assign min_sel = cmd.bwd ? (tag_k == NB_DOWN || tag_k == NB_RIGHT)
                           : (tag_k == NB_UP || tag_k == NB_LEFT);

  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      acc_any <= 1'b0;
      acc_all <= 1'b1;
      acc_rim <= 1'b0;
      acc_min <= DEPTH_CAP;
    end else if (tag_vld) begin
      if (tag_k == NB_CENTER) begin
        cen_cnt <= count_rd;
        cen_dep <= depth_rd;
        cen_fl  <= fluid_rd;
      end
      if (tag_inb) begin
        if (count_rd != '0) acc_any <= 1'b1;
        if (!dil_rd) acc_all <= 1'b0;
        if (tag_k != NB_CENTER && !fluid_rd) acc_rim <= 1'b1;
        if (min_sel && depth_rd < acc_min) acc_min <= depth_rd;
      end
    end
  end

  // Hash pipeline, free running on the held cell and frame.
  always_ff @(posedge clk) begin
    p_col <= 32'(cur_c) * HASH_COL;
    p_row <= 32'(cur_r) * HASH_ROW;
    p_frm <= frame_latch * HASH_FRM;
    h_q   <= p_col ^ p_row ^ p_frm;
    h3    <= h_q;
    h2    <= h_q * HASH_MIX;
    qprod <= 64'(h_q) * 64'(RECIP_100);
    hmod  <= 7'(h3 - 32'(qprod[63:RECIP_SH]) * 32'd100);
  end

  // Bit-serial remainders of the two offset fields by the slack.
  assign tx = {rx[3:0], dvx[MOD_BITS-1]};
  assign ty = {ry[3:0], dvy[MOD_BITS-1]};

  always_ff @(posedge clk) begin
    if (cmd.mod_init) begin
      dvx <= {8'd0, h2[31:16]};
      dvy <= h2[31:8];
      rx  <= '0;
      ry  <= '0;
    end else if (cmd.mod_step) begin
      dvx <= dvx << 1;
      dvy <= dvy << 1;
      rx  <= (tx >= {1'b0, slack}) ? 5'(tx - {1'b0, slack}) : tx;
      ry  <= (ty >= {1'b0, slack}) ? 5'(ty - {1'b0, slack}) : ty;
    end
  end

  always_comb begin
    f_class = CLASS_AIR;
    f_alpha = '0;
    f_color = '0;
    f_spk   = 1'b0;
    f_dx    = '0;
    f_dy    = '0;
    tier    = (cen_dep >= 7'd6) ? TIER_MAX : cen_dep[2:0];
    a9      = {1'b0, tier_alpha(tier)};
    if (cen_cnt == 8'd1)      a9 = 9'(a9 - JITTER);
    else if (cen_cnt >= 8'd3) a9 = 9'(a9 + JITTER);
    if (render_mode) begin
      if (cen_dep != '0) begin
        f_class = tier;
        f_alpha = a9[8] ? 8'd255 : a9[7:0];
        f_color = fmdc_pkg::tier_color(tier);
      end
    end else if (cen_fl) begin
      if (acc_rim) begin
        f_class = CLASS_RIM;
      end else begin
        f_class = CLASS_BODY;
        if (hmod < chance) begin
          f_spk = 1'b1;
          if (slack != '0) begin
            f_dx = rx[3:0];
            f_dy = ry[3:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_zero) begin
      cell_class <= CLASS_AIR;
      alpha      <= '0;
      tier_color <= '0;
      sparkle    <= 1'b0;
      sparkle_dx <= '0;
      sparkle_dy <= '0;
    end else if (cmd.finish) begin
      cell_class <= f_class;
      alpha      <= f_alpha;
      tier_color <= f_color;
      sparkle    <= f_spk;
      sparkle_dx <= f_dx;
      sparkle_dy <= f_dy;
    end
  end

endmodule

// ----- design/fluid_mask_depth_classifier.sv -----
// Fluid mask depth classifier for a ROWS x COLS grid of particle counts.
// Requests arrive on the input channel (in_valid / in_stall) and are taken
// at a clock edge with in_valid high and in_stall low. A write request
// stores one cell count (ignored outside the grid) and gives no result.
// A process request runs four raster passes over the grid (dilation,
// erosion with depth seeding, forward chamfer, backward chamfer); each
// cell steps through its five neighbor reads in turn, since they share
// one read address into the memories, and a frame gives no result.
// A read request walks the same five-neighbor sequence and then a
// bit-serial remainder unit for the sparkle offsets before its result
// appears; a read outside the grid answers with all fields zero on the
// next cycle. The result is held on the output channel (out_valid /
// out_stall) until the receiver takes it; while it waits, and while a
// request is being worked, in_stall is high. After reset the block
// sweeps the fluid mask and depth memories to zero, one cell per cycle
// until every cell is cleared, with in_stall high.
// Configuration writes (cfg_valid / cfg_ready) are always taken.
module fluid_mask_depth_classifier #(
  parameter int ROWS = fmdc_pkg::DEF_ROWS,
  parameter int COLS = fmdc_pkg::DEF_COLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [4:0]  row,
  input  logic [5:0]  col,
  input  logic [7:0]  particle_count,
  input  logic [31:0] frame_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  cell_class,
  output logic [7:0]  alpha,
  output logic [15:0] tier_color,
  output logic        sparkle,
  output logic [3:0]  sparkle_dx,
  output logic [3:0]  sparkle_dy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import fmdc_pkg::*;

  fmdc_cmd_t cmd;
  fmdc_sts_t sts;

  // Registers are plain flops and can take a write on any cycle.
  assign cfg_ready = 1'b1;

  // The sequencer owns the handshakes and the pass/step bookkeeping.
  fmdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the grid memories, the accumulators, the hash
  // pipeline and the result registers.
  fmdc_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .row            (row),
    .col            (col),
    .particle_count (particle_count),
    .frame_number   (frame_number),
    .cell_class     (cell_class),
    .alpha          (alpha),
    .tier_color     (tier_color),
    .sparkle        (sparkle),
    .sparkle_dx     (sparkle_dx),
    .sparkle_dy     (sparkle_dy)
  );

endmodule
